// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion shorthands; clk and rst_n come from the
// module that uses them
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent in this cycle implies consequent in the same cycle
`define RBB_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// condition holds at every clock edge outside reset
`define RBB_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed: invariant");

`endif

// ===== src/rbb_pkg.sv =====
// ----------------------------------------------------------------------------
// rbb_pkg
// Widths, constants, arctangent table and pipeline payload types for the
// rotated box bounds unit
// ----------------------------------------------------------------------------
package rbb_pkg;

  // coordinate and angle formats
  localparam int COORD_WIDTH   = 32;
  localparam int ANGLE_WIDTH   = 16;
  localparam int CORDIC_STAGES = 16;

  // cordic datapath: Q2.30 vectors, angle in units of 2^-32 turn
  localparam int CORDIC_W    = 32;
  localparam int FRAC_BITS   = 30;
  localparam int UNIT_W      = FRAC_BITS + 1;
  localparam int ANGLE_SHIFT = CORDIC_W - ANGLE_WIDTH;
  localparam int ARC_IDX_W   = 5;

  // cycles from input transfer to result strobe
  localparam int LATENCY = CORDIC_STAGES + 5;

  localparam logic signed [CORDIC_W-1:0] GAIN_Q30 = 32'sd652032874;

  // arctangent of 2^-idx in units of 2^-32 turn
  function automatic logic [CORDIC_W-1:0] arc_angle(input logic [ARC_IDX_W-1:0] idx);
    logic [CORDIC_W-1:0] a;
    case (idx)
      5'd0:    a = 32'd536870912;
      5'd1:    a = 32'd316933406;
      5'd2:    a = 32'd167458907;
      5'd3:    a = 32'd85004756;
      5'd4:    a = 32'd42667331;
      5'd5:    a = 32'd21354465;
      5'd6:    a = 32'd10679838;
      5'd7:    a = 32'd5340245;
      5'd8:    a = 32'd2670163;
      5'd9:    a = 32'd1335087;
      5'd10:   a = 32'd667544;
      5'd11:   a = 32'd333772;
      5'd12:   a = 32'd166886;
      5'd13:   a = 32'd83443;
      5'd14:   a = 32'd41722;
      5'd15:   a = 32'd20861;
      5'd16:   a = 32'd10430;
      5'd17:   a = 32'd5215;
      5'd18:   a = 32'd2608;
      5'd19:   a = 32'd1304;
      5'd20:   a = 32'd652;
      5'd21:   a = 32'd326;
      5'd22:   a = 32'd163;
      5'd23:   a = 32'd81;
      default: a = '0;
    endcase
    return a;
  endfunction

  // rotation vector and residual angle carried through the cell chain
  typedef struct packed {
    logic signed [CORDIC_W-1:0] x;
    logic signed [CORDIC_W-1:0] y;
    logic signed [CORDIC_W-1:0] z;
  } rbb_rot_t;

  // box data riding alongside the rotation
  typedef struct packed {
    logic                          zero;
    logic                          swap;
    logic signed [COORD_WIDTH-1:0] ax;
    logic signed [COORD_WIDTH-1:0] ay;
    logic signed [COORD_WIDTH-1:0] bx;
    logic signed [COORD_WIDTH-1:0] by;
    logic        [COORD_WIDTH-1:0] dx;
    logic        [COORD_WIDTH-1:0] dy;
    logic signed [COORD_WIDTH:0]   sx;
    logic signed [COORD_WIDTH:0]   sy;
  } rbb_side_t;

endpackage

// ===== src/rbb_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// rbb_cordic_cell
// One rotation-mode cordic iteration; passes the box data to the next cell
// ----------------------------------------------------------------------------
module rbb_cordic_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [rbb_pkg::ARC_IDX_W-1:0] stage_idx,
  input  logic                          in_valid,
  input  rbb_pkg::rbb_rot_t             rot_in,
  input  rbb_pkg::rbb_side_t            side_in,
  output logic                          out_valid,
  output rbb_pkg::rbb_rot_t             rot_out,
  output rbb_pkg::rbb_side_t            side_out
);

  logic signed [rbb_pkg::CORDIC_W-1:0] xs;
  logic signed [rbb_pkg::CORDIC_W-1:0] ys;
  logic signed [rbb_pkg::CORDIC_W-1:0] arc;
  rbb_pkg::rbb_rot_t                   rot_nxt;
  rbb_pkg::rbb_rot_t                   rot_r;
  rbb_pkg::rbb_side_t                  side_r;
  logic                                valid_r;

  // floor shifts of both vector parts
  assign xs  = rot_in.x >>> stage_idx;
  assign ys  = rot_in.y >>> stage_idx;
  assign arc = $signed(rbb_pkg::arc_angle(stage_idx));

  // rotate toward zero residual angle
  always_comb begin
    if (!rot_in.z[rbb_pkg::CORDIC_W-1]) begin
      rot_nxt.x = rot_in.x - ys;
      rot_nxt.y = rot_in.y + xs;
      rot_nxt.z = rot_in.z - arc;
    end else begin
      rot_nxt.x = rot_in.x + ys;
      rot_nxt.y = rot_in.y - xs;
      rot_nxt.z = rot_in.z + arc;
    end
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    rot_r  <= rot_nxt;
    side_r <= side_in;
  end

  assign out_valid = valid_r;
  assign rot_out   = rot_r;
  assign side_out  = side_r;

endmodule

// ===== src/rbb_extent_unit.sv =====
// ----------------------------------------------------------------------------
// rbb_extent_unit
// Clamps sine and cosine, forms the doubled rotated half-extents and the
// bounds in four registered stages
// ----------------------------------------------------------------------------
module rbb_extent_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  input  rbb_pkg::rbb_rot_t                     rot_in,
  input  rbb_pkg::rbb_side_t                    side_in,
  output logic                                  out_valid,
  output logic signed [rbb_pkg::COORD_WIDTH-1:0] low_x,
  output logic signed [rbb_pkg::COORD_WIDTH-1:0] low_y,
  output logic signed [rbb_pkg::COORD_WIDTH-1:0] high_x,
  output logic signed [rbb_pkg::COORD_WIDTH-1:0] high_y
);

  localparam int CW     = rbb_pkg::COORD_WIDTH;
  localparam int UW     = rbb_pkg::UNIT_W;
  localparam int FB     = rbb_pkg::FRAC_BITS;
  localparam int PROD_W = CW + UW;
  localparam int EXT_W  = CW + 2;
  localparam int SUM_W  = CW + 3;

  localparam logic signed [rbb_pkg::CORDIC_W-1:0] UNIT_ONE_S =
    {{(rbb_pkg::CORDIC_W - FB - 1){1'b0}}, 1'b1, {FB{1'b0}}};
  localparam logic [UW-1:0] UNIT_ONE = {1'b1, {FB{1'b0}}};
  localparam logic signed [SUM_W-1:0] SAT_HI = $signed(SUM_W'({1'b0, {(CW-1){1'b1}}}));
  localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

  // halve with floor and saturate to the coordinate range
  function automatic logic signed [CW-1:0] sat_half(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] h;
    logic signed [CW-1:0]    r;
    h = v >>> 1;
    if (h > SAT_HI) begin
      r = SAT_HI[CW-1:0];
    end else if (h < SAT_LO) begin
      r = SAT_LO[CW-1:0];
    end else begin
      r = h[CW-1:0];
    end
    return r;
  endfunction

  // clamp a cordic output to [0, 1] in Q2.30
  function automatic logic [UW-1:0] clamp_unit(input logic signed [rbb_pkg::CORDIC_W-1:0] v);
    logic [UW-1:0] r;
    if (v[rbb_pkg::CORDIC_W-1]) begin
      r = '0;
    end else if (v > UNIT_ONE_S) begin
      r = UNIT_ONE;
    end else begin
      r = v[UW-1:0];
    end
    return r;
  endfunction

  logic                     v1_r, v2_r, v3_r, v4_r;
  logic [UW-1:0]            cs_nxt, sn_nxt, cs_r, sn_r;
  rbb_pkg::rbb_side_t       side1_r, side2_r, side3_r;
  logic [PROD_W-1:0]        pxc_r, pys_r, pxs_r, pyc_r;
  logic [EXT_W-1:0]         ex_nxt, ey_nxt, ex_r, ey_r;
  logic signed [SUM_W-1:0]  sxw, syw, exw, eyw;
  logic signed [CW-1:0]     low_x_nxt, low_y_nxt, high_x_nxt, high_y_nxt;
  logic signed [CW-1:0]     low_x_r, low_y_r, high_x_r, high_y_r;

  // clamp and quadrant swap
  always_comb begin
    if (side_in.swap) begin
      cs_nxt = clamp_unit(rot_in.y);
      sn_nxt = clamp_unit(rot_in.x);
    end else begin
      cs_nxt = clamp_unit(rot_in.x);
      sn_nxt = clamp_unit(rot_in.y);
    end
  end

  // doubled extents from the floored products
  assign ex_nxt = EXT_W'(pxc_r[PROD_W-1:FB]) + EXT_W'(pys_r[PROD_W-1:FB]);
  assign ey_nxt = EXT_W'(pxs_r[PROD_W-1:FB]) + EXT_W'(pyc_r[PROD_W-1:FB]);

  // centre sums and extents at the final width
  assign sxw = SUM_W'(side3_r.sx);
  assign syw = SUM_W'(side3_r.sy);
  assign exw = $signed(SUM_W'(ex_r));
  assign eyw = $signed(SUM_W'(ey_r));

  // bounds, or the corners as given when the angle is zero
  always_comb begin
    if (side3_r.zero) begin
      low_x_nxt  = side3_r.ax;
      low_y_nxt  = side3_r.ay;
      high_x_nxt = side3_r.bx;
      high_y_nxt = side3_r.by;
    end else begin
      low_x_nxt  = sat_half(sxw - exw);
      low_y_nxt  = sat_half(syw - eyw);
      high_x_nxt = sat_half(sxw + exw);
      high_y_nxt = sat_half(syw + eyw);
    end
  end

  // stage valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    cs_r     <= cs_nxt;
    sn_r     <= sn_nxt;
    side1_r  <= side_in;
    pxc_r    <= PROD_W'(side1_r.dx) * PROD_W'(cs_r);
    pys_r    <= PROD_W'(side1_r.dy) * PROD_W'(sn_r);
    pxs_r    <= PROD_W'(side1_r.dx) * PROD_W'(sn_r);
    pyc_r    <= PROD_W'(side1_r.dy) * PROD_W'(cs_r);
    side2_r  <= side1_r;
    ex_r     <= ex_nxt;
    ey_r     <= ey_nxt;
    side3_r  <= side2_r;
    low_x_r  <= low_x_nxt;
    low_y_r  <= low_y_nxt;
    high_x_r <= high_x_nxt;
    high_y_r <= high_y_nxt;
  end

  assign out_valid = v4_r;
  assign low_x     = low_x_r;
  assign low_y     = low_y_r;
  assign high_x    = high_x_r;
  assign high_y    = high_y_r;

endmodule

// ===== src/rotated_box_bounds_unit.sv =====
// ----------------------------------------------------------------------------
// rotated_box_bounds_unit
// Axis-aligned bounds of a box rotated about its centre by a binary angle
// ----------------------------------------------------------------------------
// One box is taken every clock cycle and busy is never raised. Each result
// appears on the out_ ports with out_valid high for exactly one cycle, in
// input order; there is no back-pressure, so the receiver must take every
// strobe. The pipeline is an input stage, the chain of cordic cells, one
// iteration per cell, and four stages for clamping, the four products, the
// extent sums and the saturated bounds. A zero angle returns the corners as
// given, unordered.
`include "assert_macros.svh"

module rotated_box_bounds_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [rbb_pkg::COORD_WIDTH-1:0] in_corner_a_x,
  input  logic signed [rbb_pkg::COORD_WIDTH-1:0] in_corner_a_y,
  input  logic signed [rbb_pkg::COORD_WIDTH-1:0] in_corner_b_x,
  input  logic signed [rbb_pkg::COORD_WIDTH-1:0] in_corner_b_y,
  input  logic signed [rbb_pkg::ANGLE_WIDTH-1:0] in_turn_angle,
  output logic                                  out_valid,
  output logic signed [rbb_pkg::COORD_WIDTH-1:0] out_low_x,
  output logic signed [rbb_pkg::COORD_WIDTH-1:0] out_low_y,
  output logic signed [rbb_pkg::COORD_WIDTH-1:0] out_high_x,
  output logic signed [rbb_pkg::COORD_WIDTH-1:0] out_high_y
);

  localparam int CW = rbb_pkg::COORD_WIDTH;
  localparam int AW = rbb_pkg::ANGLE_WIDTH;
  localparam int NS = rbb_pkg::CORDIC_STAGES;

  logic signed [CW:0]   diff_x, diff_y;
  logic                 accept;
  rbb_pkg::rbb_rot_t    rot_nxt;
  rbb_pkg::rbb_side_t   side_nxt;
  logic                 valid_c [0:NS];
  rbb_pkg::rbb_rot_t    rot_c   [0:NS];
  rbb_pkg::rbb_side_t   side_c  [0:NS];
  logic                 valid0_r;
  rbb_pkg::rbb_rot_t    rot0_r;
  rbb_pkg::rbb_side_t   side0_r;

  // a new box can be taken every cycle
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // corner differences at one extra bit
  assign diff_x = {in_corner_b_x[CW-1], in_corner_b_x} - {in_corner_a_x[CW-1], in_corner_a_x};
  assign diff_y = {in_corner_b_y[CW-1], in_corner_b_y} - {in_corner_a_y[CW-1], in_corner_a_y};

  // input stage: sizes, centre sums and quadrant fold
  always_comb begin
    side_nxt.zero = (in_turn_angle == '0);
    side_nxt.swap = in_turn_angle[AW-2];
    side_nxt.ax   = in_corner_a_x;
    side_nxt.ay   = in_corner_a_y;
    side_nxt.bx   = in_corner_b_x;
    side_nxt.by   = in_corner_b_y;
    side_nxt.dx   = diff_x[CW] ? CW'(-diff_x) : CW'(diff_x);
    side_nxt.dy   = diff_y[CW] ? CW'(-diff_y) : CW'(diff_y);
    side_nxt.sx   = {in_corner_a_x[CW-1], in_corner_a_x} + {in_corner_b_x[CW-1], in_corner_b_x};
    side_nxt.sy   = {in_corner_a_y[CW-1], in_corner_a_y} + {in_corner_b_y[CW-1], in_corner_b_y};
    rot_nxt.x     = rbb_pkg::GAIN_Q30;
    rot_nxt.y     = '0;
    rot_nxt.z     = $signed(rbb_pkg::CORDIC_W'({in_turn_angle[AW-3:0],
                                                 {rbb_pkg::ANGLE_SHIFT{1'b0}}}));
  end

  // input stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid0_r <= 1'b0;
    end else begin
      valid0_r <= accept;
    end
  end

  // input stage payload
  always_ff @(posedge clk) begin
    rot0_r  <= rot_nxt;
    side0_r <= side_nxt;
  end

  assign valid_c[0] = valid0_r;
  assign rot_c[0]   = rot0_r;
  assign side_c[0]  = side0_r;

  // chain of cordic cells, one iteration each
  for (genvar g = 0; g < NS; g++) begin : g_cell
    rbb_cordic_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .stage_idx (rbb_pkg::ARC_IDX_W'(g)),
      .in_valid  (valid_c[g]),
      .rot_in    (rot_c[g]),
      .side_in   (side_c[g]),
      .out_valid (valid_c[g+1]),
      .rot_out   (rot_c[g+1]),
      .side_out  (side_c[g+1])
    );
  end

  // extents and saturated bounds
  rbb_extent_unit u_extent (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (valid_c[NS]),
    .rot_in    (rot_c[NS]),
    .side_in   (side_c[NS]),
    .out_valid (out_valid),
    .low_x     (out_low_x),
    .low_y     (out_low_y),
    .high_x    (out_high_x),
    .high_y    (out_high_y)
  );

  // a strobe only follows an earlier transfer
  `RBB_ASSERT_IMPLY(a_strobe_latency, out_valid, $past(start, rbb_pkg::LATENCY))
  // a rotated box is always ordered min to max in x
  `RBB_ASSERT_IMPLY(a_ordered_x, out_valid && ($past(in_turn_angle, rbb_pkg::LATENCY) != '0), out_low_x <= out_high_x)
  // a zero angle passes the first corner through
  `RBB_ASSERT_IMPLY(a_zero_pass, out_valid && ($past(in_turn_angle, rbb_pkg::LATENCY) == '0), out_low_x == $past(in_corner_a_x, rbb_pkg::LATENCY))
  // never stalls the sender
  `RBB_ASSERT_ALWAYS(a_never_busy, !busy)

endmodule
